// File: hdl/ttps_pkg.sv
`timescale 1ns / 1ps

package ttps_pkg;

  localparam int unsigned KeyW   = 64;
  localparam int unsigned DepthW = 8;
  localparam int unsigned ScoreW = 32;
  localparam int unsigned KindW  = 2;

  // Depth of the queue between front and back.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    OP_PROBE = 1'b0,
    OP_STORE = 1'b1
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_EXACT = 2'd0,
    KIND_UPPER = 2'd1,
    KIND_LOWER = 2'd2
  } kind_e;

  // Classified command handed from front to back.
  typedef struct packed {
    op_e                      op;
    logic [KeyW-1:0]          key;
    logic [DepthW-1:0]        depth;
    logic signed [ScoreW-1:0] alpha;
    logic signed [ScoreW-1:0] beta;
    logic signed [ScoreW-1:0] score;
    logic [KindW-1:0]         kind;
  } cmd_t;

  // One table slot as held in the RAM.
  typedef struct packed {
    logic                     valid;
    logic [KeyW-1:0]          key;
    logic [DepthW-1:0]        depth;
    logic signed [ScoreW-1:0] score;
    logic [KindW-1:0]         kind;
  } entry_t;

  // Status reported by the back part to the front part.
  typedef struct packed {
    logic clearing;
  } back_stat_t;

endpackage

// File: hdl/ttps_in_if.sv
`timescale 1ns / 1ps

interface ttps_in_if;
  logic               valid;
  logic               ready;
  logic               mode;
  logic [63:0]        position_key;
  logic [7:0]         search_depth;
  logic signed [31:0] lower_bound;
  logic signed [31:0] upper_bound;
  logic signed [31:0] score;
  logic [1:0]         bound_kind;

  modport source (
    output valid, mode, position_key, search_depth, lower_bound, upper_bound, score,
           bound_kind,
    input  ready
  );

  modport sink (
    input  valid, mode, position_key, search_depth, lower_bound, upper_bound, score,
           bound_kind,
    output ready
  );
endinterface

// File: hdl/ttps_out_if.sv
`timescale 1ns / 1ps

interface ttps_out_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] result_score;

  modport source (
    output valid, hit, result_score,
    input  ready
  );

  modport sink (
    input  valid, hit, result_score,
    output ready
  );
endinterface

// File: hdl/ttps_front.sv
`timescale 1ns / 1ps

module ttps_front
  import ttps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  ttps_in_if.sink    in_i,
  input  back_stat_t stat_i,
  output logic       push_valid_o,
  output cmd_t       push_cmd_o,
  input  logic       push_ready_i
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  // Hold off input transactions while the table is being cleared.
  assign in_i.ready = !stat_i.clearing && (!valid_q || push_ready_i);
  assign take       = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    cmd_d   = cmd_q;
    if (valid_q && push_ready_i) begin
      valid_d = 1'b0;
    end
    if (take) begin
      valid_d     = 1'b1;
      cmd_d.op    = in_i.mode ? OP_STORE : OP_PROBE;
      cmd_d.key   = in_i.position_key;
      cmd_d.depth = in_i.search_depth;
      cmd_d.alpha = in_i.lower_bound;
      cmd_d.beta  = in_i.upper_bound;
      cmd_d.score = in_i.score;
      cmd_d.kind  = in_i.bound_kind;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
  end

  assign push_valid_o = valid_q;
  assign push_cmd_o   = cmd_q;

endmodule

// File: hdl/ttps_queue.sv
`timescale 1ns / 1ps

module ttps_queue
  import ttps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  input  cmd_t push_cmd_i,
  output logic push_ready_o,
  output logic pop_valid_o,
  output cmd_t pop_cmd_o,
  input  logic pop_ready_i
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  cmd_t            ent_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_cmd_o    = ent_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// File: hdl/ttps_back.sv
`timescale 1ns / 1ps

module ttps_back
  import ttps_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  input  cmd_t       pop_cmd_i,
  output logic       pop_ready_o,
  output back_stat_t stat_o,
  ttps_out_if.source out_o
);

  localparam int unsigned Slots = 2 ** INDEX_BITS;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EVAL  = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic [INDEX_BITS-1:0]   clr_cnt_q, clr_cnt_d;
  entry_t                  slot_mem_q [Slots];
  entry_t                  rd_q;
  cmd_t                    cur_q, cur_d;

  logic                    mem_we;
  logic [INDEX_BITS-1:0]   mem_wa;
  entry_t                  mem_wd;
  logic                    rd_en;
  logic [INDEX_BITS-1:0]   rd_addr;

  logic                    out_valid_q, out_valid_d;
  logic                    out_hit_q, out_hit_d;
  logic signed [ScoreW-1:0] out_score_q, out_score_d;
  logic                    out_free;

  logic                    match;
  logic                    eval_hit;
  logic signed [ScoreW-1:0] eval_score;

  assign out_free = !out_valid_q || out_o.ready;
  assign rd_addr  = pop_cmd_i.key[INDEX_BITS-1:0];

  // Probe decision on the registered slot read.
  always_comb begin
    match      = rd_q.valid && (rd_q.key == cur_q.key) && (rd_q.depth >= cur_q.depth);
    eval_hit   = 1'b0;
    eval_score = '0;
    if (match) begin
      unique case (kind_e'(rd_q.kind))
        KIND_EXACT: begin
          eval_hit   = 1'b1;
          eval_score = rd_q.score;
        end
        KIND_UPPER: begin
          if ($signed(rd_q.score) <= $signed(cur_q.alpha)) begin
            eval_hit   = 1'b1;
            eval_score = cur_q.alpha;
          end
        end
        KIND_LOWER: begin
          if ($signed(rd_q.score) >= $signed(cur_q.beta)) begin
            eval_hit   = 1'b1;
            eval_score = cur_q.beta;
          end
        end
        default: begin
          // unused kind code: treat as a miss
          eval_hit   = 1'b0;
          eval_score = '0;
        end
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    cur_d       = cur_q;
    pop_ready_o = 1'b0;
    mem_we      = 1'b0;
    mem_wa      = rd_addr;
    mem_wd      = '0;
    rd_en       = 1'b0;
    out_valid_d = out_valid_q;
    out_hit_d   = out_hit_q;
    out_score_d = out_score_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        // sweep every slot invalid, one per cycle
        mem_we    = 1'b1;
        mem_wa    = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (pop_valid_i && out_free) begin
          pop_ready_o = 1'b1;
          if (pop_cmd_i.op == OP_STORE) begin
            mem_we       = 1'b1;
            mem_wd.valid = 1'b1;
            mem_wd.key   = pop_cmd_i.key;
            mem_wd.depth = pop_cmd_i.depth;
            mem_wd.score = pop_cmd_i.score;
            mem_wd.kind  = pop_cmd_i.kind;
            out_valid_d  = 1'b1;
            out_hit_d    = 1'b0;
            out_score_d  = '0;
          end else begin
            rd_en   = 1'b1;
            cur_d   = pop_cmd_i;
            state_d = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        out_valid_d = 1'b1;
        out_hit_d   = eval_hit;
        out_score_d = eval_score;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    out_hit_q   <= out_hit_d;
    out_score_q <= out_score_d;
  end

  // Slot RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= slot_mem_q[rd_addr];
    end
  end

  assign stat_o.clearing    = (state_q == S_CLEAR);
  assign out_o.valid        = out_valid_q;
  assign out_o.hit          = out_hit_q;
  assign out_o.result_score = out_score_q;

endmodule

// File: hdl/transposition_table_probe_store.sv
`timescale 1ns / 1ps
// Channel  Dir  Payload
// in_i     in   mode, position_key, search_depth, lower_bound, upper_bound, score, bound_kind
// out_o    out  hit, result_score
//
// One transaction in gives one transaction out. After the front register and the queue,
// a store writes the slot RAM and the output register in the back part; a probe reads
// the slot RAM into a register (S_IDLE), then compares (S_EVAL). The back part takes one
// item at a time. After reset all 2**INDEX_BITS slots (65536 by default) are swept invalid;
// in_i.ready stays low during the sweep. A stall on out_o backs up through the queue.

module transposition_table_probe_store
  import ttps_pkg::*;
#(
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ttps_in_if.sink    in_i,
  ttps_out_if.source out_o
);

  logic       push_valid, push_ready;
  cmd_t       push_cmd;
  logic       pop_valid, pop_ready;
  cmd_t       pop_cmd;
  back_stat_t stat;

  ttps_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .stat_i       (stat),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  ttps_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_cmd_o    (pop_cmd),
    .pop_ready_i  (pop_ready)
  );

  ttps_back #(
    .INDEX_BITS (INDEX_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_cmd_i   (pop_cmd),
    .pop_ready_o (pop_ready),
    .stat_o      (stat),
    .out_o       (out_o)
  );

endmodule
